>>> design/bfei_pkg.sv
`timescale 1ns / 1ps

package bfei_pkg;

	localparam int STORE_BYTES    = 4096;
	localparam int MAX_FIELD_BITS = 32;

	localparam int BYTE_W      = 8;
	localparam int BIT_ADDR_W  = 15;
	localparam int FIELD_W_W   = 6;
	localparam int VALUE_W     = 32;
	localparam int OFF_W       = 3;
	localparam int BYTE_ADDR_W = $clog2(STORE_BYTES);
	localparam int COUNT_W     = $clog2(MAX_FIELD_BITS + 1);

	typedef logic [BYTE_ADDR_W-1:0] baddr_t;
	typedef logic [COUNT_W-1:0]     count_t;

	typedef enum logic {
		FUNC_EXTRACT = 1'b0,
		FUNC_INSERT  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MERGE,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the accepted request
		logic rd;      // read the current byte
		logic step;    // merge read byte, write back on insert, advance
		logic finish;  // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic n_zero;     // no field bits left
		logic is_insert;  // current request is an insert
	} sts_t;

endpackage

>>> design/bfei_if.sv
`timescale 1ns / 1ps

interface bfei_req_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [bfei_pkg::BIT_ADDR_W-1:0] bit_address;
	logic [bfei_pkg::FIELD_W_W-1:0]  field_width;
	logic [bfei_pkg::VALUE_W-1:0]    insert_value;

	modport source (output valid, func, bit_address, field_width, insert_value, input ready);
	modport sink (input valid, func, bit_address, field_width, insert_value, output ready);
endinterface

interface bfei_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bfei_pkg::VALUE_W-1:0] field_value;

	modport source (output valid, field_value, input ready);
	modport sink (input valid, field_value, output ready);
endinterface

>>> design/bfei_ram.sv
`timescale 1ns / 1ps

module bfei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/bfei_ctrl.sv
`timescale 1ns / 1ps

module bfei_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  bfei_pkg::sts_t   sts,
	output bfei_pkg::cmd_t   cmd
);

	bfei_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfei_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bfei_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bfei_pkg::ST_READ;
				end
			end
			bfei_pkg::ST_READ: begin
				if (sts.n_zero) begin
					state_d = bfei_pkg::ST_FINISH;
				end else begin
					cmd.rd  = 1'b1;
					state_d = bfei_pkg::ST_MERGE;
				end
			end
			bfei_pkg::ST_MERGE: begin
				cmd.step = 1'b1;
				state_d  = bfei_pkg::ST_READ;
			end
			bfei_pkg::ST_FINISH: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = bfei_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfei_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/bfei_dp.sv
`timescale 1ns / 1ps

module bfei_dp (
	input  logic                              clk,
	input  bfei_pkg::cmd_t                    cmd,
	output bfei_pkg::sts_t                    sts,
	input  logic                              func,
	input  logic [bfei_pkg::BIT_ADDR_W-1:0]   bit_address,
	input  logic [bfei_pkg::FIELD_W_W-1:0]    field_width,
	input  logic [bfei_pkg::VALUE_W-1:0]      insert_value,
	output logic [bfei_pkg::VALUE_W-1:0]      field_value,
	output logic                              ram_we
);

	logic                               func_q;
	bfei_pkg::baddr_t                   bp_q;
	logic [bfei_pkg::OFF_W-1:0]         off_q;
	bfei_pkg::count_t                   n_q;
	bfei_pkg::count_t                   have_q;
	logic [bfei_pkg::VALUE_W-1:0]       acc_q;
	logic [bfei_pkg::VALUE_W-1:0]       src_q;
	logic [bfei_pkg::VALUE_W-1:0]       echo_q;
	logic [bfei_pkg::VALUE_W-1:0]       out_q;

	logic [bfei_pkg::BYTE_W-1:0]        rdata;
	logic [bfei_pkg::BYTE_W-1:0]        wdata;
	logic [bfei_pkg::OFF_W:0]           room;
	logic [bfei_pkg::OFF_W:0]           take;
	logic [bfei_pkg::BYTE_W-1:0]        mask8;
	logic [bfei_pkg::BYTE_W-1:0]        hole8;
	logic [bfei_pkg::BYTE_W-1:0]        ins8;
	logic [bfei_pkg::BYTE_W-1:0]        got8;
	bfei_pkg::count_t                   width_sat;

	assign width_sat = (field_width > bfei_pkg::FIELD_W_W'(bfei_pkg::MAX_FIELD_BITS))
		? bfei_pkg::count_t'(bfei_pkg::MAX_FIELD_BITS)
		: bfei_pkg::count_t'(field_width);

	assign room  = (bfei_pkg::OFF_W + 1)'(bfei_pkg::BYTE_W) - {1'b0, off_q};
	assign take  = (n_q < bfei_pkg::count_t'(room)) ? (bfei_pkg::OFF_W + 1)'(n_q) : room;
	assign mask8 = bfei_pkg::BYTE_W'(((bfei_pkg::BYTE_W + 1)'(1) << take)
		- (bfei_pkg::BYTE_W + 1)'(1));
	assign hole8 = bfei_pkg::BYTE_W'(mask8 << off_q);
	assign ins8  = bfei_pkg::BYTE_W'((src_q[bfei_pkg::BYTE_W-1:0] & mask8) << off_q);
	assign wdata = (rdata & ~hole8) | ins8;
	assign got8  = (rdata >> off_q) & mask8;

	assign ram_we = cmd.step && func_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			bp_q   <= bfei_pkg::baddr_t'(bit_address >> bfei_pkg::OFF_W);
			off_q  <= bit_address[bfei_pkg::OFF_W-1:0];
			n_q    <= width_sat;
			have_q <= '0;
			acc_q  <= '0;
			src_q  <= insert_value;
			echo_q <= insert_value;
		end else if (cmd.step) begin
			acc_q  <= acc_q | (bfei_pkg::VALUE_W'(got8) << have_q);
			src_q  <= src_q >> take;
			n_q    <= n_q - bfei_pkg::count_t'(take);
			have_q <= have_q + bfei_pkg::count_t'(take);
			off_q  <= '0;
			bp_q   <= bp_q + 1'b1;
		end
		if (cmd.finish) begin
			out_q <= func_q ? echo_q : acc_q;
		end
	end

	bfei_ram #(
		.WIDTH (bfei_pkg::BYTE_W),
		.DEPTH (bfei_pkg::STORE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bp_q),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (bp_q),
		.rdata (rdata)
	);

	assign sts.n_zero    = (n_q == '0);
	assign sts.is_insert = func_q;
	assign field_value   = out_q;

endmodule

>>> design/bit_field_extract_insert.sv
`timescale 1ns / 1ps

// Bit-field extract / insert unit over a 4096-byte store.
// Requests arrive on req (func, bit_address, field_width, insert_value) and
// results leave on rsp (field_value), both valid/ready; a beat moves when
// valid and ready are high at a rising clk edge.
// An extract returns the field zero-extended; an insert writes the low bits
// of insert_value into the field and echoes insert_value. Widths above 32
// saturate to 32; width 0 reads 0 and writes nothing. Byte addresses wrap.
// One request is worked at a time. It touches B bytes (0..5), each one
// through the store (read, then merge and write back), and the next
// request is accepted only after its result is loaded.
// A finished result sits in an output register, so the next request is
// accepted while rsp is stalled; a second result waits in the finishing
// step until the register frees.
// Reset clears the controller and the output valid at once; the store is
// not cleared and must be written by inserts before it is read.
module bit_field_extract_insert (
	input logic            clk,
	input logic            arst_n,
	bfei_req_if.sink       req,
	bfei_rsp_if.source     rsp
);

	bfei_pkg::cmd_t cmd;
	bfei_pkg::sts_t sts;
	logic           ram_we;

	// sequence the byte steps
	bfei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// address, mask, merge and the store itself
	bfei_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.sts          (sts),
		.func         (req.func),
		.bit_address  (req.bit_address),
		.field_width  (req.field_width),
		.insert_value (req.insert_value),
		.field_value  (rsp.field_value),
		.ram_we       (ram_we)
	);

	// the store is written only by an insert
	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> sts.is_insert)
		else $error("store written during extract");

	// one request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while busy");

	// a result appears only from the finishing step
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.finish))
		else $error("result valid without finish");

endmodule
